/* hdl/swmp_pkg.sv */
// Package for the sliding-window mean and 95th-percentile block.
// Holds the sequencer state type and fixed field widths; no dependencies.
`timescale 1ns / 1ps
package swmp_pkg;
    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OLD,
        ST_WAIT_OLD,
        ST_REM_RD,
        ST_REM_CHK,
        ST_INS_RD,
        ST_INS_CHK,
        ST_P95_RD,
        ST_P95_WAIT,
        ST_DIV,
        ST_OUT
    } t_state;
endpackage

/* hdl/sliding_window_mean_p95.sv */
// Sliding-window latency mean and 95th percentile, one result per sample.
// Steps from accept to result valid: if the window is full and not restarting, a read of the
// oldest sample and a removal walk over the sorted entries; then the insertion walk, a read of
// the p95 entry and the bit-serial divider (one quotient bit per cycle).
// Throughput: one request at a time; the next is accepted the cycle after the result is taken.
// Reset (synchronous, active low) empties the window; memories are not cleared.
`timescale 1ns / 1ps
module sliding_window_mean_p95 #(
    parameter int WINDOW_DEPTH = 200
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] latency_us
    input  logic        s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // [7:0] sample_count, [39:8] mean_us, [71:40] p95_us
);
    import swmp_pkg::*;

    localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = SAMPLE_W + CW;
    localparam int DCW   = $clog2(SUM_W + 1);
    localparam int PW    = CW + 5;
    // ceil(2^20 / 20): exact floor(x/20) for every x below 2^18
    localparam int RECIP_20 = 52429;

    t_state r_state, n_state;

    // ring and sorted copy, one write and one read port each, registered reads
    logic [SAMPLE_W-1:0] r_ring   [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] r_sorted [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] r_ring_q, r_sort_q;

    logic [AW-1:0]       r_slot;
    logic                r_filled;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_old;
    logic [AW-1:0]       r_idx;      // walk pointer
    logic [CW-1:0]       r_len;      // entries in sorted copy during walk
    logic                r_found;    // removal hit found, now shifting down
    logic [CW-1:0]       r_count;
    logic [SUM_W-1:0]    r_rem;      // divider remainder
    logic [SUM_W-1:0]    r_quo;      // dividend shifted out / quotient in
    logic [DCW-1:0]      r_dcnt;
    logic [SAMPLE_W-1:0] r_p95;

    // sorted memory port controls
    logic                s_wr_en;
    logic [AW-1:0]       s_wr_addr, s_rd_addr;
    logic [SAMPLE_W-1:0] s_wr_data;

    logic [PW-1:0]       w_p95_prod;
    logic [PW+16-1:0]    w_p95_mul;
    logic [AW-1:0]       w_p95_idx;
    logic [SUM_W:0]      w_trial;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {8'd0, r_p95, r_quo[SAMPLE_W-1:0], COUNT_W'(r_count)};

    // floor(count*19/20): multiply by small constant, then reciprocal multiply for the /20
    assign w_p95_prod = PW'(r_count) * PW'(19);
    assign w_p95_mul  = (PW+16)'(w_p95_prod) * (PW+16)'(RECIP_20);
    always_comb begin
        logic [PW-1:0] q;
        q = PW'(w_p95_mul >> 20);
        if (q >= PW'(WINDOW_DEPTH)) q = PW'(WINDOW_DEPTH - 1);
        w_p95_idx = q[AW-1:0];
    end

    assign w_trial = {r_rem, r_quo[SUM_W-1]} - {1'b0, (SUM_W)'(r_count)};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (s_axis_tvalid) begin
                             n_state = (r_filled && !s_axis_tuser) ? ST_RD_OLD : ST_INS_RD;
                         end
            ST_RD_OLD:   n_state = ST_WAIT_OLD;
            ST_WAIT_OLD: n_state = ST_REM_RD;
            ST_REM_RD:   n_state = ST_REM_CHK;
            ST_REM_CHK:  n_state = (32'(r_idx) + 1 >= 32'(r_len)) ? ST_INS_RD : ST_REM_RD;
            ST_INS_RD:   n_state = (r_idx == '0 && r_len == '0) ? ST_P95_RD : ST_INS_CHK;
            ST_INS_CHK:  n_state = (r_idx == '0 || r_sort_q <= r_sample) ? ST_P95_RD : ST_INS_RD;
            ST_P95_RD:   n_state = ST_P95_WAIT;
            ST_P95_WAIT: n_state = ST_DIV;
            ST_DIV:      n_state = (r_dcnt == DCW'(1)) ? ST_OUT : ST_DIV;
            ST_OUT:      if (m_axis_tready) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // memory port controls
    always_comb begin
        s_wr_en   = 1'b0;
        s_wr_addr = r_idx;
        s_wr_data = r_sort_q;
        s_rd_addr = r_idx;
        case (r_state)
            ST_REM_CHK: begin
                // shift down once the old value is found
                if (r_found || r_sort_q == r_old) begin
                    s_wr_en   = r_found;
                    s_wr_addr = r_idx - AW'(1);
                end
                s_rd_addr = r_idx + AW'(1);
            end
            ST_INS_RD: begin
                s_rd_addr = r_idx - AW'(1);
                if (r_len == '0) begin
                    s_wr_en   = 1'b1;
                    s_wr_data = r_sample;
                end
            end
            ST_INS_CHK: begin
                s_wr_en = 1'b1;
                if (r_idx == '0 || r_sort_q <= r_sample) begin
                    s_wr_data = r_sample;
                end else begin
                    s_wr_data = r_sort_q;
                end
            end
            ST_P95_RD:  s_rd_addr = w_p95_idx;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_wr_en) r_sorted[s_wr_addr] <= s_wr_data;
        r_sort_q <= r_sorted[s_rd_addr];
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_ring[(s_axis_tuser ? AW'(0) : r_slot)] <= s_axis_tdata;
        end
        if (r_state == ST_IDLE) r_ring_q <= r_ring[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_slot   <= '0;
            r_filled <= 1'b0;
            r_sum    <= '0;
            r_found  <= 1'b0;
            r_count  <= '0;
            r_dcnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: if (s_axis_tvalid) begin
                    // take the request; restart empties the window first
                    r_sample <= s_axis_tdata;
                    r_found  <= 1'b0;
                    if (s_axis_tuser) begin
                        r_sum  <= (SUM_W)'(s_axis_tdata);
                        r_len  <= '0;
                        r_idx  <= '0;
                        r_slot <= (WINDOW_DEPTH == 1) ? AW'(0) : AW'(1);
                        r_filled <= (WINDOW_DEPTH == 1);
                        r_count  <= CW'(1);
                    end else begin
                        r_sum <= r_sum + (SUM_W)'(s_axis_tdata);
                        if (r_filled) begin
                            r_len <= CW'(WINDOW_DEPTH);
                            r_idx <= '0;
                        end else begin
                            r_len <= CW'(r_slot);
                            r_idx <= r_slot;
                        end
                        if (32'(r_slot) + 1 >= WINDOW_DEPTH) begin
                            r_slot   <= '0;
                            r_filled <= 1'b1;
                            r_count  <= CW'(WINDOW_DEPTH);
                        end else begin
                            r_slot  <= r_slot + AW'(1);
                            r_count <= r_filled ? CW'(WINDOW_DEPTH) : CW'(r_slot) + CW'(1);
                        end
                    end
                end
                ST_WAIT_OLD: begin
                    // drop the oldest sample from the sum
                    r_old <= r_ring_q;
                    r_sum <= r_sum - (SUM_W)'(r_ring_q);
                end
                ST_REM_CHK: begin
                    if (r_sort_q == r_old) r_found <= 1'b1;
                    if (32'(r_idx) + 1 >= 32'(r_len)) begin
                        r_len <= r_len - CW'(1);
                        r_idx <= AW'(r_len - CW'(1));
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                ST_INS_CHK: begin
                    if (!(r_idx == '0 || r_sort_q <= r_sample)) r_idx <= r_idx - AW'(1);
                end
                ST_P95_WAIT: begin
                    r_p95  <= r_sort_q;
                    r_rem  <= '0;
                    r_quo  <= r_sum;
                    r_dcnt <= DCW'(SUM_W);
                end
                ST_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (!w_trial[SUM_W]) begin
                        r_rem <= w_trial[SUM_W-1:0];
                        r_quo <= {r_quo[SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[SUM_W-2:0], r_quo[SUM_W-1]};
                        r_quo <= {r_quo[SUM_W-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - DCW'(1);
                end
                default: ;
            endcase
        end
    end

    // result count never zero when offered
    a_count_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_count != '0) else $error("zero count on output");
    // not ready while a result is offered
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
    // divider count never zero in the divide phase
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> r_dcnt != '0) else $error("divider count underflow");
endmodule

/* verif/swmp_checker.sv */
// Checker for the sliding-window mean and 95th-percentile block.
// Watches both stream channels, predicts each result and compares; needs swmp_pkg.
`timescale 1ns / 1ps
module swmp_checker #(
    parameter int WINDOW_DEPTH = 200
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,    // [31:0] latency_us
    input  logic        i_req_user,    // [0] restart
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [79:0] i_res_data,    // [7:0] sample_count, [39:8] mean_us, [71:40] p95_us
    output int          o_fail_count,
    output int          o_pending
);
    import swmp_pkg::*;

    // highest field first, so count lands in the lowest bits
    typedef struct packed {
        logic [SAMPLE_W-1:0] p95;
        logic [SAMPLE_W-1:0] mean;
        logic [COUNT_W-1:0]  count;
    } t_window_stats;

    logic [SAMPLE_W-1:0] ring_copy [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] sorted_copy [WINDOW_DEPTH];
    int unsigned         next_slot;
    bit                  wrapped;
    logic [63:0]         latency_total;
    t_window_stats       stats_due[$];

    // Take one occurrence of the value out of the first len sorted entries.
    function automatic void drop_sorted(int unsigned len, logic [SAMPLE_W-1:0] v);
        for (int i = 0; i < len; i++) begin
            if (sorted_copy[i] == v) begin
                for (int k = i; k + 1 < len; k++) sorted_copy[k] = sorted_copy[k + 1];
                return;
            end
        end
    endfunction

    function automatic void place_sorted(int unsigned len, logic [SAMPLE_W-1:0] v);
        int unsigned pos;
        pos = len;
        while (pos > 0 && sorted_copy[pos - 1] > v) begin
            sorted_copy[pos] = sorted_copy[pos - 1];
            pos--;
        end
        sorted_copy[pos] = v;
    endfunction

    function automatic t_window_stats window_stats(logic [SAMPLE_W-1:0] sample, bit restart);
        t_window_stats s;
        int unsigned   cnt;
        int unsigned   idx;
        if (restart) begin
            next_slot     = 0;
            wrapped       = 0;
            latency_total = '0;
        end
        if (wrapped) begin
            latency_total -= ring_copy[next_slot];
            drop_sorted(WINDOW_DEPTH, ring_copy[next_slot]);
            place_sorted(WINDOW_DEPTH - 1, sample);
        end else begin
            place_sorted(next_slot, sample);
        end
        ring_copy[next_slot] = sample;
        latency_total += sample;
        next_slot++;
        if (next_slot >= WINDOW_DEPTH) begin
            next_slot = 0;
            wrapped   = 1;
        end
        cnt = wrapped ? WINDOW_DEPTH : next_slot;
        idx = (cnt * 19) / 20;
        if (idx >= WINDOW_DEPTH) idx = WINDOW_DEPTH - 1;
        s.count = cnt[COUNT_W-1:0];
        s.mean  = 32'(latency_total / cnt);
        s.p95   = sorted_copy[idx];
        return s;
    endfunction

    assign o_pending = stats_due.size();

    always @(posedge i_clk) begin
        t_window_stats want, got;
        int            errs;
        if (!i_rst_n) begin
            next_slot     = 0;
            wrapped       = 0;
            latency_total = '0;
            stats_due.delete();
            o_fail_count <= 0;
        end else begin
            errs = 0;
            if (i_req_valid && i_req_ready)
                stats_due.push_back(window_stats(i_req_data, i_req_user));
            if (i_res_valid && i_res_ready) begin
                got = i_res_data[71:0];
                if (stats_due.size() == 0) begin
                    $error("result with nothing expected: %h", i_res_data);
                    errs = errs + 1;
                end else begin
                    want = stats_due.pop_front();
                    if (got.count != want.count) begin
                        $error("sample_count expected %0d got %0d", want.count, got.count);
                        errs = errs + 1;
                    end
                    if (got.mean != want.mean) begin
                        $error("mean_us expected %0d got %0d", want.mean, got.mean);
                        errs = errs + 1;
                    end
                    if (got.p95 != want.p95) begin
                        $error("p95_us expected %0d got %0d", want.p95, got.p95);
                        errs = errs + 1;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

/* verif/tb_top.sv */
// Top of the testbench for sliding_window_mean_p95: clock, reset, stimulus, verdict.
// Depends on swmp_pkg, the block and swmp_checker.
`timescale 1ns / 1ps
module tb_top;
    localparam int DEPTH      = 200;
    localparam int CYCLE_CAP  = 4_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // [31:0] latency_us
    logic        s_axis_tuser;    // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;    // [7:0] sample_count, [39:8] mean_us, [71:40] p95_us
    int          fail_count;
    int          pending;
    int          cycle_no = 0;
    bit          hold_sink;       // long receiver hold-off requested

    sliding_window_mean_p95 #(.WINDOW_DEPTH(DEPTH)) dut (.*);

    swmp_checker #(.WINDOW_DEPTH(DEPTH)) u_checker (
        .i_clk, .i_rst_n,
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_req_user(s_axis_tuser),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > CYCLE_CAP) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Offer one request, idling a random number of cycles first unless eager.
    task automatic send_sample(logic [31:0] lat, bit restart, bit eager);
        int gap;
        gap = eager ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= lat;
        s_axis_tuser  <= restart;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Random sample: mix extremes, small values, repeats and full range.
    function automatic logic [31:0] pick_latency();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom_range(0, 3);
            2: return $urandom_range(1000, 50000);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stalls, 1 in 4 items with none, plus one long hold-off.
    initial begin
        int stall;
        bit held;
        held = 0;
        m_axis_tready = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_sink && !held) begin
                m_axis_tready <= 0;
                repeat (3000) @(posedge i_clk);
                held = 1;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                if (stall != 0) begin
                    m_axis_tready <= 0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        s_axis_tvalid = 0;
        s_axis_tdata  = 0;
        s_axis_tuser  = 0;
        i_rst_n       = 0;
        hold_sink     = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, duplicates, restart mid-window, restart first.
        send_sample(32'hFFFF_FFFF, 1, 0);
        send_sample(32'hFFFF_FFFF, 0, 0);
        send_sample(0, 0, 0);
        send_sample(32'h5555_5555, 0, 0);
        send_sample(32'hAAAA_AAAA, 0, 0);
        send_sample(7, 0, 0);
        send_sample(7, 0, 0);
        send_sample(7, 1, 0);
        send_sample(0, 1, 0);
        for (int i = 0; i < 12; i++) send_sample(32'hFFFF_FFFF - i, 0, 1);

        // Hold the receiver off while requests keep coming, so the block stalls.
        hold_sink = 1;
        for (int i = 0; i < 6; i++) send_sample(pick_latency(), 0, 1);
        // Pause until every result has drained.
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // Random: mostly long runs so the ring wraps, rare restarts.
        for (int i = 0; i < 830; i++)
            send_sample(pick_latency(), ($urandom_range(0, 299) == 0), $urandom_range(0, 4) == 0);

        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

/* files.f */
hdl/swmp_pkg.sv
hdl/sliding_window_mean_p95.sv
verif/swmp_checker.sv
verif/tb_top.sv
